/* hdl/lpd_pkg.sv */
package lpd_pkg;

  localparam int unsigned LenBytes   = 4;
  localparam int unsigned TypeBytes  = 2;
  localparam int unsigned LenWidth   = 32;
  localparam int unsigned TypeWidth  = 16;
  localparam int unsigned TotalWidth = 21;
  localparam int unsigned CntWidth   = 2;

  localparam logic [TotalWidth-1:0] MaxLimit      = 21'd1048576;
  localparam logic [TotalWidth-1:0] MaxLenDefault = 21'd65536;

  typedef enum logic [1:0] {
    PhLen  = 2'd0,
    PhType = 2'd1,
    PhPay  = 2'd2,
    PhErr  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEmpty = 2'd1,
    KindShort = 2'd2,
    KindLarge = 2'd3
  } kind_e;

endpackage

/* hdl/length_prefixed_deframer_unit.sv */
// Result path: a byte transfer loads the input register, which feeds the result register
//   once the output is free (no result held, or the held result being taken).
// Throughput: one byte per cycle while results are taken; a held result stalls the
//   input once the input register is also full.
// Reset: asynchronous, active low; returns to the length header phase, clears the
//   error lock and sets the maximum frame length to 65536.
module length_prefixed_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [20:0] cfg_data_i,     // max_frame_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // message_type[15:0], payload_byte[23:16],
                                      // frame_total[44:24], zeros[47:45]
  output logic [1:0]  m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned LW = lpd_pkg::LenWidth;
  localparam int unsigned TW = lpd_pkg::TypeWidth;
  localparam int unsigned FW = lpd_pkg::TotalWidth;
  localparam int unsigned CW = lpd_pkg::CntWidth;

  logic [FW-1:0]    max_len_q;

  logic             byte_vld_q;
  logic [7:0]       byte_q;

  lpd_pkg::phase_e  phase_q, phase_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [LW-1:0]    len_q, len_d;
  logic [TW-1:0]    type_q, type_d;
  logic [FW-1:0]    rem_q, rem_d;

  logic             out_vld_q;
  lpd_pkg::kind_e   out_kind_q;
  logic [TW-1:0]    out_type_q;
  logic [7:0]       out_data_q;
  logic             out_last_q;
  logic [FW-1:0]    out_total_q;

  logic             out_free;
  logic             step;
  logic             emit;
  lpd_pkg::kind_e   res_kind;
  logic [TW-1:0]    res_type;
  logic [7:0]       res_data;
  logic             res_last;
  logic [FW-1:0]    res_total;

  logic [LW-1:0]    len_shift;
  logic [TW-1:0]    type_shift;
  logic [FW-1:0]    rem_dec;
  logic [FW-1:0]    limit;
  logic [FW-1:0]    total;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = byte_vld_q && out_free;
  assign s_axis_tready = !byte_vld_q || out_free;
  assign cfg_ready_o   = 1'b1;

  assign len_shift  = {len_q[LW-9:0], byte_q};
  assign type_shift = {type_q[TW-9:0], byte_q};
  assign rem_dec    = rem_q - FW'(1);
  assign limit      = (max_len_q > lpd_pkg::MaxLimit) ? lpd_pkg::MaxLimit : max_len_q;
  assign total      = len_q[FW-1:0] + FW'(lpd_pkg::LenBytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpd_pkg::MaxLenDefault;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      byte_vld_q <= 1'b1;
    end else if (step) begin
      byte_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpd_pkg::PhLen;
      cnt_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      type_q  <= type_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    type_d    = type_q;
    rem_d     = rem_q;
    emit      = 1'b0;
    res_kind  = lpd_pkg::KindData;
    res_type  = '0;
    res_data  = '0;
    res_last  = 1'b0;
    res_total = '0;
    if (step) begin
      case (phase_q)
        lpd_pkg::PhLen: begin
          len_d = len_shift;
          if (cnt_q == CW'(lpd_pkg::LenBytes - 1)) begin
            cnt_d = '0;
            if (len_shift < LW'(lpd_pkg::TypeBytes)) begin
              phase_d  = lpd_pkg::PhErr;
              emit     = 1'b1;
              res_kind = lpd_pkg::KindShort;
            end else if (len_shift > LW'(limit)) begin
              phase_d  = lpd_pkg::PhErr;
              emit     = 1'b1;
              res_kind = lpd_pkg::KindLarge;
            end else begin
              type_d  = '0;
              phase_d = lpd_pkg::PhType;
            end
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
        lpd_pkg::PhType: begin
          type_d = type_shift;
          if (cnt_q == CW'(lpd_pkg::TypeBytes - 1)) begin
            cnt_d = '0;
            rem_d = len_q[FW-1:0] - FW'(lpd_pkg::TypeBytes);
            if (len_q == LW'(lpd_pkg::TypeBytes)) begin
              phase_d   = lpd_pkg::PhLen;
              len_d     = '0;
              emit      = 1'b1;
              res_kind  = lpd_pkg::KindEmpty;
              res_type  = type_shift;
              res_last  = 1'b1;
              res_total = total;
            end else begin
              phase_d = lpd_pkg::PhPay;
            end
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
        lpd_pkg::PhPay: begin
          rem_d    = rem_dec;
          emit     = 1'b1;
          res_kind = lpd_pkg::KindData;
          res_type = type_q;
          res_data = byte_q;
          if (rem_dec == '0) begin
            phase_d   = lpd_pkg::PhLen;
            len_d     = '0;
            res_last  = 1'b1;
            res_total = total;
          end
        end
        default: begin
          phase_d = lpd_pkg::PhErr;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_kind_q  <= res_kind;
      out_type_q  <= res_type;
      out_data_q  <= res_data;
      out_last_q  <= res_last;
      out_total_q <= res_total;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_total_q, out_data_q, out_type_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* sim/length_prefixed_deframer_checker.sv */
`timescale 1ns / 100ps
module length_prefixed_deframer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [20:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o
);

  typedef struct packed {
    lpd_pkg::kind_e                 kind;
    logic [lpd_pkg::TypeWidth-1:0]  msg_type;
    logic [7:0]                     data;
    logic                           last;
    logic [lpd_pkg::TotalWidth-1:0] total;
  } deframe_result_t;

  deframe_result_t                frame_results_q[$];
  lpd_pkg::phase_e                phase;
  logic [2:0]                     hdr_cnt;
  logic [lpd_pkg::LenWidth-1:0]   len_acc;
  logic [lpd_pkg::TypeWidth-1:0]  type_acc;
  logic [lpd_pkg::TotalWidth-1:0] remaining;
  logic [lpd_pkg::TotalWidth-1:0] max_len;
  int unsigned                    fails;
  int unsigned                    results;

  task automatic deframe_byte(input logic [7:0] b);
    deframe_result_t                r;
    logic [lpd_pkg::TotalWidth-1:0] limit;
    r = '0;
    case (phase)
      lpd_pkg::PhLen: begin
        len_acc = {len_acc[lpd_pkg::LenWidth-9:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt == lpd_pkg::LenBytes) begin
          hdr_cnt = '0;
          limit = (max_len > lpd_pkg::MaxLimit) ? lpd_pkg::MaxLimit : max_len;
          if (len_acc < lpd_pkg::TypeBytes) begin
            phase = lpd_pkg::PhErr;
            r.kind = lpd_pkg::KindShort;
            frame_results_q.insert(frame_results_q.size(), r);
          end else if (len_acc > limit) begin
            phase = lpd_pkg::PhErr;
            r.kind = lpd_pkg::KindLarge;
            frame_results_q.insert(frame_results_q.size(), r);
          end else begin
            type_acc = '0;
            phase = lpd_pkg::PhType;
          end
        end
      end
      lpd_pkg::PhType: begin
        type_acc = {type_acc[7:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt == lpd_pkg::TypeBytes) begin
          hdr_cnt = '0;
          remaining = lpd_pkg::TotalWidth'(len_acc - lpd_pkg::TypeBytes);
          if (remaining == '0) begin
            phase = lpd_pkg::PhLen;
            r.kind = lpd_pkg::KindEmpty;
            r.msg_type = type_acc;
            r.last = 1'b1;
            r.total = lpd_pkg::TotalWidth'(lpd_pkg::LenBytes + len_acc);
            len_acc = '0;
            frame_results_q.insert(frame_results_q.size(), r);
          end else begin
            phase = lpd_pkg::PhPay;
          end
        end
      end
      lpd_pkg::PhPay: begin
        remaining = remaining - 1'b1;
        r.kind = lpd_pkg::KindData;
        r.msg_type = type_acc;
        r.data = b;
        if (remaining == '0) begin
          phase = lpd_pkg::PhLen;
          r.last = 1'b1;
          r.total = lpd_pkg::TotalWidth'(lpd_pkg::LenBytes + len_acc);
          len_acc = '0;
        end
        frame_results_q.insert(frame_results_q.size(), r);
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input deframe_result_t e, input deframe_result_t a);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected kind %0d type %h byte %h last %b total %0d", $realtime, what,
               e.kind, e.msg_type, e.data, e.last, e.total);
      $display("%0t: %s: got      kind %0d type %h byte %h last %b total %0d", $realtime, what,
               a.kind, a.msg_type, a.data, a.last, a.total);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deframe_result_t seen;
    deframe_result_t want;
    if (!rst_ni) begin
      phase = lpd_pkg::PhLen;
      hdr_cnt = '0;
      len_acc = '0;
      type_acc = '0;
      remaining = '0;
      max_len = lpd_pkg::MaxLenDefault;
      frame_results_q.delete();
      fails = 0;
      results = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      result_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_len = cfg_data_i;
      if (s_tvalid_i && s_tready_i) deframe_byte(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        results++;
        seen.kind = lpd_pkg::kind_e'(m_tuser_i);
        seen.msg_type = m_tdata_i[15:0];
        seen.data = m_tdata_i[23:16];
        seen.total = m_tdata_i[44:24];
        seen.last = m_tlast_i;
        if (frame_results_q.size() == 0) begin
          report("result with nothing outstanding", '0, seen);
        end else begin
          want = frame_results_q.pop_front();
          if (seen != want || m_tdata_i[47:45] != '0) report("mismatch", want, seen);
        end
      end
      fail_count_o <= fails;
      pending_o <= frame_results_q.size();
      result_count_o <= results;
    end
  end

endmodule

/* sim/length_prefixed_deframer_unit_test.sv */
`timescale 1ns / 100ps
module length_prefixed_deframer_unit_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [20:0] cfg_data = '0;
  logic        cfg_ready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned bytes_sent = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req = 1'b0;
  logic [20:0] max_now = lpd_pkg::MaxLenDefault;
  string       ending = "no error";

  always #2 clk = ~clk;

  length_prefixed_deframer_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  length_prefixed_deframer_checker deframe_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tlast_i      (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [20:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_now = v;
  endtask

  // split: length byte before which the limit is rewritten, -1 for none
  task automatic send_frame(input logic [31:0] len, input logic [15:0] msg_type, input int split,
                            input logic [20:0] split_max);
    for (int i = 0; i < 4; i++) begin
      if (i == split) write_max(split_max);
      send_byte(len[8*(3-i) +: 8]);
    end
    send_byte(msg_type[15:8]);
    send_byte(msg_type[7:0]);
    for (int unsigned i = 2; i < len; i++) send_byte(8'($urandom));
  endtask

  function automatic logic [15:0] rand_type();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_len(input int unsigned cap);
    case ($urandom_range(0, 9))
      0: return 32'd2;
      1: return cap;
      default: return $urandom_range(2, (cap > 24) ? 24 : cap);
    endcase
  endfunction

  task automatic random_frames(input int unsigned target, input int unsigned bound);
    int unsigned cap;
    cap = (max_now < bound) ? max_now : bound;
    while (bytes_sent < target) send_frame(pick_len(cap), rand_type(), -1, '0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("length_prefixed_deframer_unit regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] bad_len;
    int unsigned wait_cycles;
    int unsigned n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame, one-byte and two-byte payloads at the default limit
    send_frame(32'd2, 16'hFFFF, -1, '0);
    send_frame(32'd3, 16'h0000, -1, '0);
    send_frame(32'd4, 16'h8001, -1, '0);

    random_frames(160, 40);
    hold_req = 1'b1;
    send_frame(32'd50, rand_type(), -1, '0);
    wait_drained();

    write_max(21'd2);
    random_frames(250, 2);

    write_max(lpd_pkg::MaxLimit);
    send_frame(32'd120, rand_type(), -1, '0);
    random_frames(400, 40);

    write_max(21'h1F_FFFF);
    random_frames(470, 40);

    n = $urandom_range(3, 30);
    write_max(21'(n));
    send_frame(32'(n), rand_type(), -1, '0);
    random_frames(540, n);

    // limit raised between length bytes, applies at this frame's check
    write_max(21'd10);
    send_frame(32'd24, rand_type(), 2, 21'd24);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_frames(660, 24);

    case ($urandom_range(0, 3))
      0: begin
        bad_len = $urandom_range(0, 1);
        ending = "a too-short length";
      end
      1: begin
        bad_len = $urandom_range(0, 1) ? 32'(max_now) + 32'd1 : 32'hFFFF_FFFF;
        ending = "a too-large length";
      end
      2: begin
        write_max(21'h1F_FFFF);
        bad_len = 32'(lpd_pkg::MaxLimit) + 32'd1;
        ending = "a length over the clamped oversized limit";
      end
      default: begin
        write_max(21'($urandom_range(0, 1)));
        bad_len = $urandom_range(0, 3);
        ending = "a limit below 2";
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(bad_len[8*i +: 8]);
    repeat (12) send_byte(8'($urandom));
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < 2000);
    repeat (8) @(posedge clk);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d bytes and checked %0d results across limits 2, default, max and oversized,",
             bytes_sent, result_count);
    $display("with a mid-frame limit change and a long output stall; ended on %s.", ending);
    if (fail_count == 0 && pending == 0) begin
      $display("length_prefixed_deframer_unit regression: pass");
    end else begin
      $display("length_prefixed_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
